FILE: rtl/core/pcsh_pkg.sv
// Shared types and constants for the program-counter sampling histogram.
package pcsh_pkg;

	localparam int ADDR_W    = 48;
	localparam int RANGE_W   = 2;
	localparam int BUCKET_W  = 14;
	localparam int COUNT_W   = 16;
	localparam int HITS_W    = 32;
	localparam int USED_W    = 15;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 4;

	// Range registers exist for this many ranges only.
	localparam int CFG_RANGES = 4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_PC  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd3;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic                kind;
		addr_t               sample_pc;
		logic [RANGE_W-1:0]  read_range;
		logic [BUCKET_W-1:0] read_bucket;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [RANGE_W-1:0]  range_index;
		logic [BUCKET_W-1:0] bucket_index;
		logic [COUNT_W-1:0]  bucket_count;
		logic [HITS_W-1:0]   range_hits;
		logic [USED_W-1:0]   range_used_buckets;
	} rsp_t;

	// Result of one pass through the shared range compare unit.
	typedef struct packed {
		logic  hit;
		addr_t offset;
	} match_t;

endpackage

FILE: rtl/core/pcsh_intf.sv
// Channel interfaces: sample/read requests, results and register writes.
interface pcsh_req_if;
	import pcsh_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pcsh_rsp_if;
	import pcsh_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pcsh_cfg_if;
	import pcsh_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	addr_t                value;
	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

FILE: rtl/core/pcsh_range_unit.sv
// Shared range compare unit: tests one range against the sample and forms the offset.
module pcsh_range_unit (
	input  pcsh_pkg::addr_t  pc,
	input  pcsh_pkg::addr_t  low,
	input  pcsh_pkg::addr_t  high,
	output pcsh_pkg::match_t result
);
	import pcsh_pkg::*;

	logic [ADDR_W:0] diff;

	// The borrow out of pc - low doubles as the lower bound test.
	assign diff          = {1'b0, pc} - {1'b0, low};
	assign result.hit    = !diff[ADDR_W] && (pc < high);
	assign result.offset = diff[ADDR_W-1:0];

endmodule

FILE: rtl/core/pcsh_bucket_mem.sv
// Bucket store: one write port and one read port with registered read data.
module pcsh_bucket_mem #(
	parameter int AW    = 16,
	parameter int DEPTH = 65536
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [pcsh_pkg::COUNT_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [pcsh_pkg::COUNT_W-1:0] rdata
);
	import pcsh_pkg::*;

	logic [COUNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/pc_sample_histogram.sv
// Top level of the program-counter sampling histogram.
//
//   port | role | carries
//   -----+------+--------------------------------------------------------------
//   req  | sink | kind, sample_pc, read_range, read_bucket
//   rsp  | src  | status, range_index, bucket_index, bucket_count, hits, used
//   cfg  | sink | index, value (range low/high registers, always ready)
//
// A count request searches the ranges, then checks the offset, reads the bucket and updates it:
// states S_SEARCH, S_LOCATE, S_MEMRD and S_UPDATE, with the result registered in S_UPDATE.
// A sample that matches no range answers once the last range is searched, one past the store
// after the offset check. A bucket read goes through S_MEMRD and S_UPDATE; a zero sample and a
// read of a missing range or past the store answer directly from the idle state.
// The ranges are searched by a single shared compare unit, one range per cycle.
// After reset the bucket store is cleared one entry per cycle, all NUM_RANGES (at most four)
// times 2**clog2(BUCKETS_PER_RANGE) entries (65536 by default); req is not ready meanwhile.
// A pending result holds until it is taken; a new request is taken only once it leaves.
module pc_sample_histogram #(
	parameter int NUM_RANGES        = 4,
	parameter int BUCKETS_PER_RANGE = 16384,
	parameter int BUCKET_SHIFT      = 2
) (
	input logic        clk,
	input logic        arst_n,
	pcsh_req_if.sink   req,
	pcsh_rsp_if.source rsp,
	pcsh_cfg_if.sink   cfg
);
	import pcsh_pkg::*;

	localparam int NCR   = (NUM_RANGES < CFG_RANGES) ? NUM_RANGES : CFG_RANGES;
	localparam int BW    = (BUCKETS_PER_RANGE > 1) ? $clog2(BUCKETS_PER_RANGE) : 1;
	localparam int DEPTH = NCR << BW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_LOCATE,
		S_MEMRD,
		S_UPDATE
	} state_t;

	state_t               state_q;
	req_t                 item_q;
	logic [RANGE_W-1:0]   r_q;
	addr_t                off_q;
	logic [BW-1:0]        bkt_q;
	logic [AW-1:0]        addr_q;
	logic                 out_vld_q;
	rsp_t                 out_q;
	addr_t                low_q  [NCR];
	addr_t                high_q [NCR];
	logic [HITS_W-1:0]    hits_q [NCR];
	logic [USED_W-1:0]    used_q [NCR];

	match_t               match;
	logic                 req_fire;
	logic [CFG_IDX_W-2:0] cfg_range;
	logic                 mem_we;
	logic                 mem_re;
	logic [COUNT_W-1:0]   mem_wdata;
	logic [COUNT_W-1:0]   mem_rdata;
	logic [COUNT_W-1:0]   next_count;

	function automatic logic [AW-1:0] mk_addr(logic [RANGE_W-1:0] r, logic [BW-1:0] b);
		mk_addr = (AW'(r) << BW) | AW'(b);
	endfunction

	function automatic rsp_t mk_rsp(logic [STATUS_W-1:0] st, logic [RANGE_W-1:0] r,
			logic [BUCKET_W-1:0] b, logic [COUNT_W-1:0] c, logic [HITS_W-1:0] h,
			logic [USED_W-1:0] u);
		rsp_t o;
		o.status             = st;
		o.range_index        = r;
		o.bucket_index       = b;
		o.bucket_count       = c;
		o.range_hits         = h;
		o.range_used_buckets = u;
		mk_rsp = o;
	endfunction

	pcsh_range_unit u_range (
		.pc     (item_q.sample_pc),
		.low    (low_q[r_q]),
		.high   (high_q[r_q]),
		.result (match)
	);

	pcsh_bucket_mem #(
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_q),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	assign req.ready  = (state_q == S_IDLE) && (!out_vld_q || rsp.ready);
	assign req_fire   = req.valid && req.ready;
	assign rsp.valid  = out_vld_q;
	assign rsp.data   = out_q;
	assign cfg.ready  = 1'b1;
	assign cfg_range  = cfg.index[CFG_IDX_W-1:1];
	assign next_count = mem_rdata + COUNT_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		mem_re    = (state_q == S_MEMRD);
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_UPDATE && item_q.kind == KIND_COUNT) begin
			mem_we    = 1'b1;
			mem_wdata = next_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			addr_q    <= '0;
			r_q       <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < NCR; i++) begin
				low_q[i]  <= '0;
				high_q[i] <= '0;
				hits_q[i] <= '0;
				used_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && 32'(cfg_range) < NCR) begin
				if (cfg.index[0]) begin
					high_q[cfg_range[RANGE_W-1:0]] <= cfg.value;
				end else begin
					low_q[cfg_range[RANGE_W-1:0]] <= cfg.value;
				end
			end

			// A request transfer sets the result flag itself in the idle state.
			if (out_vld_q && rsp.ready && !req_fire) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						item_q <= req.data;
						if (req.data.kind == KIND_READ) begin
							if (32'(req.data.read_range) >= NCR) begin
								out_q     <= mk_rsp(ST_NO_RANGE, req.data.read_range,
									'0, '0, '0, '0);
								out_vld_q <= 1'b1;
							end else if (32'(req.data.read_bucket) >= BUCKETS_PER_RANGE) begin
								out_q     <= mk_rsp(ST_BEYOND, req.data.read_range, '0, '0,
									hits_q[req.data.read_range],
									used_q[req.data.read_range]);
								out_vld_q <= 1'b1;
							end else begin
								r_q       <= req.data.read_range;
								bkt_q     <= BW'(req.data.read_bucket);
								addr_q    <= mk_addr(req.data.read_range,
									BW'(req.data.read_bucket));
								out_vld_q <= 1'b0;
								state_q   <= S_MEMRD;
							end
						end else if (req.data.sample_pc == '0) begin
							out_q     <= mk_rsp(ST_ZERO_PC, '0, '0, '0, '0, '0);
							out_vld_q <= 1'b1;
						end else begin
							r_q       <= '0;
							out_vld_q <= 1'b0;
							state_q   <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (match.hit) begin
						off_q   <= match.offset >> BUCKET_SHIFT;
						state_q <= S_LOCATE;
					end else if (r_q == RANGE_W'(NCR - 1)) begin
						out_q     <= mk_rsp(ST_NO_RANGE, '0, '0, '0, '0, '0);
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						r_q <= r_q + RANGE_W'(1);
					end
				end
				S_LOCATE: begin
					if (off_q >= ADDR_W'(BUCKETS_PER_RANGE)) begin
						out_q     <= mk_rsp(ST_BEYOND, r_q, '0, '0, hits_q[r_q], used_q[r_q]);
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						bkt_q   <= BW'(off_q);
						addr_q  <= mk_addr(r_q, BW'(off_q));
						state_q <= S_MEMRD;
					end
				end
				S_MEMRD: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (item_q.kind == KIND_READ) begin
						out_q <= mk_rsp(ST_OK, r_q, BUCKET_W'(bkt_q), mem_rdata,
							hits_q[r_q], used_q[r_q]);
					end else begin
						// A bucket found at zero becomes used, also after a wrap.
						hits_q[r_q] <= hits_q[r_q] + HITS_W'(1);
						used_q[r_q] <= used_q[r_q] + USED_W'(mem_rdata == '0);
						out_q <= mk_rsp(ST_OK, r_q, BUCKET_W'(bkt_q), next_count,
							hits_q[r_q] + HITS_W'(1),
							used_q[r_q] + USED_W'(mem_rdata == '0));
					end
					out_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
